// ----- rtl/gnms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_pkg
// Types and constants for the gradient non-maximum suppression block.
// ----------------------------------------------------------------------------
package gnms_pkg;

  localparam int unsigned MAG_W       = 16;
  localparam int unsigned IMG_W_BITS  = 12;
  localparam int unsigned IMG_H_BITS  = 13;
  localparam int unsigned ROW_W       = 14;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [IMG_H_BITS-1:0] MIN_HEIGHT   = 13'd3;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    DIR_H    = 2'd0,
    DIR_D45  = 2'd1,
    DIR_V    = 2'd2,
    DIR_D135 = 2'd3
  } dir_e;

  typedef struct packed {
    req_e req_type;
    mag_t magnitude;
    dir_e direction;
  } in_item_t;

  typedef struct packed {
    mag_t kept_magnitude;
    logic frame_end;
  } out_item_t;

endpackage

// ----- rtl/gradient_non_max_suppression.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_non_max_suppression
// Canny non-maximum suppression over a raster stream of gradient pixels.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per clock in steady state
// while the result channel does not stall. An item is registered together
// with its line buffer read in stage 1; as stage 1 moves on, the 3x3 window
// shifts and the result register loads for the window centre. Results lag
// the input by one row plus one pixel: after the last pixel of a frame,
// image_width+1 flush items drain the window; a flush with the raster
// position at the frame start is consumed without effect. Border pixels and
// non-maxima give 0, and frame_end marks the result of the last pixel. The
// line buffers are MAX_WIDTH-deep memories with one read and one write port,
// and need no clearing after reset. Sizes are clamped to 3..MAX_WIDTH
// columns and at least 3 rows.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAG_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  gnms_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gnms_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gnms_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gnms_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gnms_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import gnms_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = COL_W + 1;
  localparam int unsigned CMP_W = (IMG_W_BITS > WW) ? IMG_W_BITS : WW;

  // configuration
  logic [IMG_W_BITS-1:0] img_w_q;
  logic [IMG_H_BITS-1:0] img_h_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= WIDTH_RESET;
      img_h_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  img_w_q <= pwdata[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: img_h_q <= pwdata[IMG_H_BITS-1:0];
        default:          img_w_q <= img_w_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(img_w_q);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(img_h_q);
      default:          prdata = '0;
    endcase
  end

  // clamped sizes
  logic [CMP_W-1:0] w_ext;
  logic [CMP_W-1:0] w_cl;
  logic [WW-1:0]    w;
  logic [WW-1:0]    w_m1;
  logic [ROW_W-1:0] h_m1;

  always_comb begin
    w_ext = CMP_W'(img_w_q);
    if (w_ext < CMP_W'(3)) begin
      w_cl = CMP_W'(3);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_cl = CMP_W'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    w    = w_cl[WW-1:0];
    w_m1 = w - WW'(1);
    h_m1 = (img_h_q < MIN_HEIGHT) ? ROW_W'(MIN_HEIGHT) - ROW_W'(1)
                                  : ROW_W'(img_h_q) - ROW_W'(1);
  end

  // raster position and input decode
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                in_fire, in_take, flush, col_wrap, col_end;
  logic [COL_W-1:0]    c0, qc;
  logic [ROW_W-1:0]    r0, qr;
  logic                res, border, last;
  logic [MAG_BITS-1:0] m_in;
  dir_e                d_in;

  always_comb begin
    flush    = (in_data_i.req_type == REQ_FLUSH);
    in_fire  = in_valid_i & ~in_stall_o;
    in_take  = in_fire & ~(flush && row_q == '0 && col_q == '0);
    m_in     = flush ? '0 : MAG_BITS'(in_data_i.magnitude);
    d_in     = flush ? DIR_H : in_data_i.direction;
    col_wrap = ({1'b0, col_q} >= w);
    c0       = col_wrap ? '0 : col_q;
    r0       = col_wrap ? row_q + ROW_W'(1) : row_q;
    res      = !(r0 == '0 || (r0 == ROW_W'(1) && c0 == '0));
    if (c0 != '0) begin
      qc = c0 - COL_W'(1);
      qr = r0 - ROW_W'(1);
    end else begin
      qc = w_m1[COL_W-1:0];
      qr = r0 - ROW_W'(2);
    end
    border  = (qr == '0) || (qr >= h_m1) || (qc == '0) || ({1'b0, qc} == w_m1);
    last    = (qr >= h_m1) && ({1'b0, qc} == w_m1);
    col_end = ({1'b0, c0} == w_m1);
    if (res && last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_end) begin
      col_d = '0;
      row_d = r0 + ROW_W'(1);
    end else begin
      col_d = c0 + COL_W'(1);
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_take) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line buffers
  logic [2*MAG_BITS-1:0] mag_mem [MAX_WIDTH];
  dir_e                  dir_mem [MAX_WIDTH];
  logic [2*MAG_BITS-1:0] mag_rd_q;
  dir_e                  dir_rd_q;

  // stage 1
  logic                s1_valid_q, s1_res_q, s1_border_q, s1_last_q;
  logic [MAG_BITS-1:0] s1_mag_q;
  logic [COL_W-1:0]    s1_col_q;
  logic                s1_go;
  logic [MAG_BITS-1:0] top, mid;

  assign top = mag_rd_q[2*MAG_BITS-1:MAG_BITS];
  assign mid = mag_rd_q[MAG_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mag_rd_q   <= mag_mem[c0];
      dir_rd_q   <= dir_mem[c0];
      dir_mem[c0] <= d_in;
    end
    if (s1_go) begin
      mag_mem[s1_col_q] <= {mid, s1_mag_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_border_q <= border;
      s1_last_q   <= last;
      s1_mag_q    <= m_in;
      s1_col_q    <= c0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
      s1_res_q   <= res;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
    end
  end

  logic out_valid_q;
  out_item_t out_data_q;

  assign s1_go      = s1_valid_q & (~s1_res_q | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_go;

  // window: columns zero and one of the 3x3, column two comes unregistered
  logic [MAG_BITS-1:0] win_q [3][2];
  dir_e                pend_q;
  logic [MAG_BITS-1:0] cen, nb_a, nb_b, kept;

  always_comb begin
    cen = win_q[1][1];
    case (pend_q)
      DIR_H: begin
        nb_a = win_q[1][0];
        nb_b = mid;
      end
      DIR_D45: begin
        nb_a = win_q[0][0];
        nb_b = s1_mag_q;
      end
      DIR_V: begin
        nb_a = win_q[0][1];
        nb_b = win_q[2][1];
      end
      default: begin
        nb_a = top;
        nb_b = win_q[2][0];
      end
    endcase
    kept = (!s1_border_q && cen > nb_a && cen > nb_b) ? cen : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '{default: '0};
      pend_q <= DIR_H;
    end else if (s1_go) begin
      win_q[0][0] <= win_q[0][1];
      win_q[1][0] <= win_q[1][1];
      win_q[2][0] <= win_q[2][1];
      win_q[0][1] <= top;
      win_q[1][1] <= mid;
      win_q[2][1] <= s1_mag_q;
      pend_q      <= dir_rd_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_res_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_res_q) begin
      out_data_q.kept_magnitude <= mag_t'(kept);
      out_data_q.frame_end      <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_no_addr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && s1_go && c0 == s1_col_q |-> r0 == '0 && c0 == '0)
    else $error("line buffer column reused outside the frame start");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_res_q && out_valid_q)
    else $error("input stalled without a waiting result");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && res && last |=> col_q == '0 && row_q == '0)
    else $error("raster position not reset after last pixel");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_res_q |=> out_valid_q)
    else $error("result lost between stage one and output");

endmodule

// ----- sim/gnms_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_checker
// Watches the pixel and result channels and the register port, runs its own
// non-maximum suppression model on every accepted input item and compares
// each accepted result, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module gnms_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  gnms_pkg::in_item_t                in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  gnms_pkg::out_item_t               out_data_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic                              pready_i,
  input  logic [gnms_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [gnms_pkg::APB_DATA_W-1:0]   pwdata_i,
  output int unsigned                       mismatch_count_o,
  output int unsigned                       awaited_o,
  output int unsigned                       result_count_o,
  output int unsigned                       frame_count_o,
  output int unsigned                       kept_count_o
);
  import gnms_pkg::*;

  localparam int unsigned LINE_DEPTH = 2048;
  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_IMAGE_HEIGHT, 2'b00};

  logic [IMG_W_BITS-1:0] width_reg;
  logic [IMG_H_BITS-1:0] height_reg;

  mag_t        older_row [LINE_DEPTH];
  mag_t        newer_row [LINE_DEPTH];
  dir_e        dir_row   [LINE_DEPTH];
  mag_t        win [3][3];
  dir_e        centre_dir;
  dir_e        next_dir;
  int unsigned col;
  int unsigned row;

  out_item_t   kept_q[$];
  out_item_t   want;

  function automatic mag_t local_max_value();
    mag_t a;
    mag_t b;
    case (centre_dir)
      DIR_H: begin
        a = win[1][0];
        b = win[1][2];
      end
      DIR_D45: begin
        a = win[0][0];
        b = win[2][2];
      end
      DIR_V: begin
        a = win[0][1];
        b = win[2][1];
      end
      default: begin
        a = win[0][2];
        b = win[2][0];
      end
    endcase
    return (win[1][1] > a && win[1][1] > b) ? win[1][1] : '0;
  endfunction

  function automatic void predict_item(input in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned qr;
    int unsigned qc;
    mag_t        m;
    mag_t        top_m;
    mag_t        mid_m;
    dir_e        d;
    dir_e        rd;
    out_item_t   res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = height_reg;
    if (h < 3) h = 3;

    // flush with the raster at rest
    if (it.req_type == REQ_FLUSH && row == 0 && col == 0) return;

    m = (it.req_type == REQ_FLUSH) ? '0 : it.magnitude;
    d = (it.req_type == REQ_FLUSH) ? DIR_H : it.direction;

    if (col >= w) begin
      col = 0;
      row++;
    end
    r = row;
    c = col;

    top_m = older_row[c];
    mid_m = newer_row[c];
    older_row[c] = mid_m;
    newer_row[c] = m;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top_m;
    win[1][2] = mid_m;
    win[2][2] = m;

    rd = dir_row[c];
    dir_row[c] = d;
    centre_dir = next_dir;
    next_dir = rd;

    if (c >= 1) begin
      qr = r - 1;
      qc = c - 1;
    end else begin
      qr = r - 2;
      qc = w - 1;
    end

    col = c + 1;
    if (col >= w) begin
      col = 0;
      row = r + 1;
    end

    if (r == 0 || (r == 1 && c == 0)) return;

    if (qr == 0 || qr >= h - 1 || qc == 0 || qc == w - 1) res.kept_magnitude = '0;
    else res.kept_magnitude = local_max_value();
    res.frame_end = (qr >= h - 1) && (qc == w - 1);
    if (res.frame_end) begin
      row = 0;
      col = 0;
    end
    kept_q.push_back(res);
  endfunction

  function automatic void report_result(input string why, input out_item_t got,
                                        input out_item_t exp_item);
    mismatch_count_o++;
    if (mismatch_count_o <= 10)
      $display("%0t result %0d: %s, got kept=%0d end=%0b, want kept=%0d end=%0b",
               $time, result_count_o, why, got.kept_magnitude, got.frame_end,
               exp_item.kept_magnitude, exp_item.frame_end);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
        dir_row[i] = DIR_H;
      end
      foreach (win[i, j]) win[i][j] = '0;
      centre_dir = DIR_H;
      next_dir = DIR_H;
      col = 0;
      row = 0;
      kept_q.delete();
      mismatch_count_o = 0;
      result_count_o = 0;
      frame_count_o = 0;
      kept_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == WIDTH_ADDR) width_reg = pwdata_i[IMG_W_BITS-1:0];
        else if (paddr_i == HEIGHT_ADDR) height_reg = pwdata_i[IMG_H_BITS-1:0];
      end

      if (in_valid_i && !in_stall_i) predict_item(in_data_i);

      if (out_valid_i && !out_stall_i) begin
        result_count_o++;
        if (kept_q.size() == 0) begin
          report_result("no result expected", out_data_i, '0);
        end else begin
          want = kept_q.pop_front();
          if (out_data_i.kept_magnitude !== want.kept_magnitude)
            report_result("kept_magnitude differs", out_data_i, want);
          else if (out_data_i.frame_end !== want.frame_end)
            report_result("frame_end differs", out_data_i, want);
          if (want.frame_end) frame_count_o++;
          if (want.kept_magnitude != '0) kept_count_o++;
        end
      end
    end
    awaited_o = kept_q.size();
  end

endmodule

// ----- sim/gradient_non_max_suppression_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_non_max_suppression_tb
// Drives raster frames of gradient pixels and flush items into the block,
// resizes the frame over the register port between frames and once mid-frame,
// stalls both channels at random and leaves prediction and comparison to gnms_checker.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression_tb;
  import gnms_pkg::*;

  localparam int unsigned SETTLE_CYCLES     = 8;
  localparam int unsigned TAIL_CYCLES       = 32;
  localparam int unsigned SMALL_FRAME_ITEMS = 1220;
  localparam int unsigned WIDE_ITEMS        = 40;
  localparam int unsigned MAX_COLS          = 2048;
  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_IMAGE_HEIGHT, 2'b00};

  // directed 6x3 frame: one kept peak, one non-maximum, one tie, one diagonal peak
  localparam mag_t PLANE_MAG [18] = '{
    16'd0,     16'd1,     16'd2,   16'd3,   16'd4,   16'd5,
    16'd65534, 16'd65535, 16'd200, 16'd300, 16'd400, 16'd0,
    16'd0,     16'd65535, 16'd7,   16'd300, 16'd9,   16'd65535
  };
  localparam dir_e PLANE_DIR [18] = '{
    DIR_H,    DIR_V,   DIR_D45, DIR_D135, DIR_H,    DIR_V,
    DIR_H,    DIR_D45, DIR_H,   DIR_V,    DIR_D135, DIR_V,
    DIR_D135, DIR_D45, DIR_V,   DIR_H,    DIR_D135, DIR_H
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned results;
  int unsigned frames;
  int unsigned peaks;

  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned fed_items = 0;
  int unsigned frame_items = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gradient_non_max_suppression dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  gnms_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatches),
    .awaited_o        (awaited),
    .result_count_o   (results),
    .frame_count_o    (frames),
    .kept_count_o     (peaks)
  );

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall before each result
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      hold = quiet_out ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic mag_t pick_mag();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return mag_t'($urandom_range(0, 3));
      default: return mag_t'($urandom);
    endcase
  endfunction

  task automatic push_item(input in_item_t it);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fed_items++;
  endtask

  task automatic push_random(input req_e kind);
    in_item_t it;
    it.req_type = kind;
    it.magnitude = pick_mag();
    it.direction = dir_e'($urandom_range(0, 3));
    push_item(it);
  endtask

  // hold the pixel channel until every predicted result is out
  task automatic settle(input int unsigned extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic resize(input int unsigned w, input int unsigned h);
    settle(SETTLE_CYCLES);
    apb_write(WIDTH_ADDR, w);
    apb_write(HEIGHT_ADDR, h);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_w = (w < 3) ? 3 : ((w > MAX_COLS) ? MAX_COLS : w);
    cur_h = (h < 3) ? 3 : h;
  endtask

  // one frame plus its drain; noise swaps in mid-frame flushes and drain pixels
  task automatic run_frame(input bit noisy);
    int unsigned body;
    req_e        kind;
    body = cur_w * cur_h;
    for (int unsigned n = 0; n < body + cur_w + 1; n++) begin
      if (n < body)
        kind = (noisy && n != 0 && $urandom_range(0, 19) == 0) ? REQ_FLUSH : REQ_PIXEL;
      else
        kind = (noisy && $urandom_range(0, 4) == 0) ? REQ_PIXEL : REQ_FLUSH;
      push_random(kind);
      frame_items++;
    end
    repeat ($urandom_range(0, 2)) push_random(REQ_FLUSH);
  endtask

  initial begin
    in_item_t    it;
    int unsigned w;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frame
    resize(6, 3);
    push_random(REQ_FLUSH);
    for (int n = 0; n < 18; n++) begin
      it.req_type = (n == 12) ? REQ_FLUSH : REQ_PIXEL;
      it.magnitude = (n == 12) ? 16'hFFFF : PLANE_MAG[n];
      it.direction = PLANE_DIR[n];
      push_item(it);
    end
    for (int n = 0; n < 7; n++) push_random((n == 3) ? REQ_PIXEL : REQ_FLUSH);

    // widest raster, then shrink to the smallest while mid-frame
    resize(4095, 8191);
    repeat (WIDE_ITEMS) push_random(REQ_PIXEL);
    resize(0, 0);
    repeat (4 * cur_w) push_random(REQ_FLUSH);

    while (frame_items < SMALL_FRAME_ITEMS) begin
      if ($urandom_range(0, 1) == 1) begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        resize(w, $urandom_range(3, 7));
      end
      quiet_in = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      run_frame($urandom_range(0, 2) == 0);
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;

    settle(TAIL_CYCLES);
    $display("fed %0d items (%0d in random frames), %0d results, %0d frames closed",
             fed_items, frame_items, results, frames);
    $display("%0d results kept a local maximum, %0d mismatches, %0d results missing",
             peaks, mismatches, awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gnms_pkg.sv
rtl/gradient_non_max_suppression.sv
sim/gnms_checker.sv
sim/gradient_non_max_suppression_tb.sv
